/* sv/brcs_pkg.sv */
// shared constants and types for the blit rectangle clip and scale block
package brcs_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int CFG_BITS       = 15;
    localparam int APB_ADDR_BITS  = 4;
    localparam int APB_DATA_BITS  = 32;
    localparam int QUEUE_DEPTH    = 2;

    typedef enum logic [1:0] {
        REG_TILE_X,
        REG_TILE_Y,
        REG_TILE_WIDTH,
        REG_TILE_HEIGHT
    } reg_idx_t;

    typedef struct packed {
        logic [CFG_BITS-1:0] x;
        logic [CFG_BITS-1:0] y;
        logic [CFG_BITS-1:0] width;
        logic [CFG_BITS-1:0] height;
    } tile_cfg_t;

endpackage

/* sv/blit_rect_clip_and_scale.sv */
// top level: tile registers on the apb port, front end, queue and back end
// Clips a source rectangle against the tile set by tile_x, tile_y, tile_width and
// tile_height, returns the clipped source in tile-local coordinates and moves the
// destination edges by the same fractions, rounded half away from zero and saturated.
// One word is accepted per cycle while no back-pressure from out_ready holds the pipeline,
// and one result word comes out per input word. A word passes the front register, the
// queue, the product registers and the pipelined dividers (one quotient bit per stage,
// 2*COORD_BITS stages), then the rounding and output register. The user must write the
// tile registers over the apb port only while no word is in flight; the block does not enforce this.
module blit_rect_clip_and_scale #(
    parameter int COORD_BITS = brcs_pkg::COORD_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [brcs_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [brcs_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [brcs_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                               pready,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [COORD_BITS-1:0]              src_left,
    input  logic [COORD_BITS-1:0]              src_top,
    input  logic [COORD_BITS-1:0]              src_right,
    input  logic [COORD_BITS-1:0]              src_bottom,
    input  logic [COORD_BITS-1:0]              dst_left,
    input  logic [COORD_BITS-1:0]              dst_top,
    input  logic [COORD_BITS-1:0]              dst_right,
    input  logic [COORD_BITS-1:0]              dst_bottom,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               hit,
    output logic [COORD_BITS-1:0]              out_src_left,
    output logic [COORD_BITS-1:0]              out_src_top,
    output logic [COORD_BITS-1:0]              out_src_right,
    output logic [COORD_BITS-1:0]              out_src_bottom,
    output logic [COORD_BITS-1:0]              out_dst_left,
    output logic [COORD_BITS-1:0]              out_dst_top,
    output logic [COORD_BITS-1:0]              out_dst_right,
    output logic [COORD_BITS-1:0]              out_dst_bottom
);

    localparam int FW = 14*COORD_BITS + 3;
    localparam int CB = brcs_pkg::CFG_BITS;

    brcs_pkg::tile_cfg_t  cfg_reg;
    brcs_pkg::reg_idx_t   reg_idx;
    logic                 wr_en;

    logic                 f_valid, f_ready;
    logic [FW-1:0]        f_word;
    logic                 q_valid, q_ready;
    logic [FW-1:0]        q_word;

    assign pready  = 1'b1;
    assign reg_idx = brcs_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                brcs_pkg::REG_TILE_X:      cfg_reg.x      <= pwdata[CB-1:0];
                brcs_pkg::REG_TILE_Y:      cfg_reg.y      <= pwdata[CB-1:0];
                brcs_pkg::REG_TILE_WIDTH:  cfg_reg.width  <= pwdata[CB-1:0];
                brcs_pkg::REG_TILE_HEIGHT: cfg_reg.height <= pwdata[CB-1:0];
                default:                   cfg_reg        <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            brcs_pkg::REG_TILE_X:      prdata = {{(brcs_pkg::APB_DATA_BITS-CB){1'b0}}, cfg_reg.x};
            brcs_pkg::REG_TILE_Y:      prdata = {{(brcs_pkg::APB_DATA_BITS-CB){1'b0}}, cfg_reg.y};
            brcs_pkg::REG_TILE_WIDTH:  prdata = {{(brcs_pkg::APB_DATA_BITS-CB){1'b0}},
                                                 cfg_reg.width};
            brcs_pkg::REG_TILE_HEIGHT: prdata = {{(brcs_pkg::APB_DATA_BITS-CB){1'b0}},
                                                 cfg_reg.height};
            default:                   prdata = '0;
        endcase
    end

    brcs_front #(.COORD_BITS(COORD_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg),
        .in_valid(in_valid), .in_ready(in_ready),
        .src_left(src_left), .src_top(src_top),
        .src_right(src_right), .src_bottom(src_bottom),
        .dst_left(dst_left), .dst_top(dst_top),
        .dst_right(dst_right), .dst_bottom(dst_bottom),
        .out_valid(f_valid), .out_ready(f_ready), .out_word(f_word)
    );

    brcs_queue #(.W(FW)) u_queue (
        .clk(clk), .rst_n(rst_n),
        .in_valid(f_valid), .in_ready(f_ready), .in_word(f_word),
        .out_valid(q_valid), .out_ready(q_ready), .out_word(q_word)
    );

    brcs_back #(.COORD_BITS(COORD_BITS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .in_valid(q_valid), .in_ready(q_ready), .in_word(q_word),
        .out_valid(out_valid), .out_ready(out_ready), .hit(hit),
        .out_src_left(out_src_left), .out_src_top(out_src_top),
        .out_src_right(out_src_right), .out_src_bottom(out_src_bottom),
        .out_dst_left(out_dst_left), .out_dst_top(out_dst_top),
        .out_dst_right(out_dst_right), .out_dst_bottom(out_dst_bottom)
    );

endmodule

/* sv/brcs_front.sv */
// front end: overlap test, clipped source and division operands, one registered word
module brcs_front #(
    parameter int COORD_BITS = brcs_pkg::COORD_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  brcs_pkg::tile_cfg_t     cfg,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [COORD_BITS-1:0]   src_left,
    input  logic [COORD_BITS-1:0]   src_top,
    input  logic [COORD_BITS-1:0]   src_right,
    input  logic [COORD_BITS-1:0]   src_bottom,
    input  logic [COORD_BITS-1:0]   dst_left,
    input  logic [COORD_BITS-1:0]   dst_top,
    input  logic [COORD_BITS-1:0]   dst_right,
    input  logic [COORD_BITS-1:0]   dst_bottom,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [14*COORD_BITS+2:0] out_word
);

    localparam int C  = COORD_BITS;
    localparam int EW = ((C > 16) ? C : 16) + 2;
    localparam int FW = 14*C + 3;
    localparam logic signed [EW-1:0] MAXV = {{(EW-C+1){1'b0}}, {(C-1){1'b1}}};
    localparam logic signed [EW-1:0] MINV = ~MAXV;

    function automatic logic signed [EW-1:0] sx(input logic [C-1:0] v);
        sx = {{(EW-C){v[C-1]}}, v};
    endfunction

    function automatic logic signed [EW-1:0] zx(input logic [brcs_pkg::CFG_BITS-1:0] v);
        zx = {{(EW-brcs_pkg::CFG_BITS){1'b0}}, v};
    endfunction

    function automatic logic [C-1:0] sat(input logic signed [EW-1:0] v);
        logic [C-1:0] r;
        if (v > MAXV)
        begin
            r = MAXV[C-1:0];
        end
        else if (v < MINV)
        begin
            r = MINV[C-1:0];
        end
        else
        begin
            r = v[C-1:0];
        end
        sat = r;
    endfunction

    logic signed [EW-1:0] sl, st, sr, sb;
    logic signed [EW-1:0] tx, ty, txe, tye;
    logic signed [EW-1:0] w1, h1;
    logic signed [EW-1:0] vx, vy, rx, ry, wv, hv;
    logic signed [EW-1:0] nlx, nty;
    logic signed [C:0]    spanx, spany;
    logic                 hit;
    logic [FW-1:0]        word_next;
    logic [FW-1:0]        word_reg;
    logic                 valid_reg;

    assign sl  = sx(src_left);
    assign st  = sx(src_top);
    assign sr  = sx(src_right);
    assign sb  = sx(src_bottom);
    assign tx  = zx(cfg.x);
    assign ty  = zx(cfg.y);
    assign txe = tx + zx(cfg.width);
    assign tye = ty + zx(cfg.height);
    assign w1  = sr - sl;
    assign h1  = sb - st;

    assign hit = (w1 > 0) && (h1 > 0) && (sr >= tx) && (sl < txe)
                 && (sb >= ty) && (st < tye);

    assign vx  = (sl > tx) ? sl : tx;
    assign vy  = (st > ty) ? st : ty;
    assign rx  = (sr < txe) ? sr : txe;
    assign ry  = (sb < tye) ? sb : tye;
    assign wv  = rx - vx;
    assign hv  = ry - vy;
    assign nlx = vx - sl;
    assign nty = vy - st;

    assign spanx = {dst_right[C-1], dst_right} - {dst_left[C-1], dst_left};
    assign spany = {dst_bottom[C-1], dst_bottom} - {dst_top[C-1], dst_top};

    assign word_next = {hit,
                        sat(vx - tx), sat(vy - ty), sat(vx - tx + wv), sat(vy - ty + hv),
                        dst_left, dst_top, spanx, spany,
                        nlx[C-1:0], wv[C-1:0], nty[C-1:0], hv[C-1:0],
                        w1[C-1:0], h1[C-1:0]};

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg <= word_next;
        end
    end

endmodule

/* sv/brcs_queue.sv */
// two-slot queue between front end and back end
module brcs_queue #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [W-1:0] in_word,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] out_word
);

    localparam int DEPTH = brcs_pkg::QUEUE_DEPTH;

    logic [1:0]   count_reg, count_next;
    logic [W-1:0] slot0_reg, slot1_reg;
    logic         push, pop;
    logic [1:0]   pos;

    assign in_ready  = (count_reg != 2'(DEPTH));
    assign out_valid = (count_reg != 2'd0);
    assign out_word  = slot0_reg;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign pos       = count_reg - {1'b0, pop};

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && (count_reg == 2'd2))
        begin
            slot0_reg <= slot1_reg;
        end
        if (push && (pos == 2'd0))
        begin
            slot0_reg <= in_word;
        end
        if (push && (pos == 2'd1))
        begin
            slot1_reg <= in_word;
        end
    end

endmodule

/* sv/brcs_div.sv */
// pipelined restoring divider, one quotient bit per stage
module brcs_div #(
    parameter int NB = 32,
    parameter int DB = 16
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NB-1:0] dividend,
    input  logic [DB-1:0] divisor,
    output logic [NB-1:0] quotient,
    output logic [DB-1:0] remainder
);

    logic [DB-1:0] rem_reg [NB];
    logic [NB-1:0] quo_reg [NB];
    logic [DB-1:0] den_reg [NB];
    logic [NB-1:0] dvd_reg [NB];

    for (genvar s = 0; s < NB; s++)
    begin : g_stage
        logic [DB-1:0] rem_in;
        logic [NB-1:0] quo_in;
        logic [DB-1:0] den_in;
        logic [NB-1:0] dvd_in;
        logic [DB:0]   trial;
        logic [DB:0]   diff;

        if (s == 0)
        begin : g_first
            assign rem_in = '0;
            assign quo_in = '0;
            assign den_in = divisor;
            assign dvd_in = dividend;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[s-1];
            assign quo_in = quo_reg[s-1];
            assign den_in = den_reg[s-1];
            assign dvd_in = dvd_reg[s-1];
        end

        assign trial = {rem_in, dvd_in[NB-1]};
        assign diff  = trial - {1'b0, den_in};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (trial >= {1'b0, den_in})
                begin
                    rem_reg[s] <= diff[DB-1:0];
                    quo_reg[s] <= {quo_in[NB-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[s] <= trial[DB-1:0];
                    quo_reg[s] <= {quo_in[NB-2:0], 1'b0};
                end
                den_reg[s] <= den_in;
                dvd_reg[s] <= {dvd_in[NB-2:0], 1'b0};
            end
        end
    end

    assign quotient  = quo_reg[NB-1];
    assign remainder = rem_reg[NB-1];

endmodule

/* sv/brcs_back.sv */
// back end: products, four dividers, rounding and the output register
module brcs_back #(
    parameter int COORD_BITS = brcs_pkg::COORD_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [14*COORD_BITS+2:0] in_word,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     hit,
    output logic [COORD_BITS-1:0]    out_src_left,
    output logic [COORD_BITS-1:0]    out_src_top,
    output logic [COORD_BITS-1:0]    out_src_right,
    output logic [COORD_BITS-1:0]    out_src_bottom,
    output logic [COORD_BITS-1:0]    out_dst_left,
    output logic [COORD_BITS-1:0]    out_dst_top,
    output logic [COORD_BITS-1:0]    out_dst_right,
    output logic [COORD_BITS-1:0]    out_dst_bottom
);

    localparam int C   = COORD_BITS;
    localparam int NB  = 2*C;
    localparam int RW  = C + 4;
    localparam int SBW = 8*C + 3;
    localparam logic signed [RW-1:0] MAXV = {{(RW-C+1){1'b0}}, {(C-1){1'b1}}};
    localparam logic signed [RW-1:0] MINV = ~MAXV;

    function automatic logic signed [RW-1:0] floor_q(input logic neg,
                                                     input logic [NB-1:0] q0,
                                                     input logic [C-1:0] r0);
        logic signed [RW-1:0] q;
        q = {{(RW-C-1){1'b0}}, q0[C:0]};
        if (neg)
        begin
            q = (r0 != '0) ? (-q - RW'(1)) : -q;
        end
        floor_q = q;
    endfunction

    function automatic logic [C-1:0] floor_f(input logic neg, input logic [C-1:0] r0,
                                             input logic [C-1:0] den);
        logic [C-1:0] f;
        f = r0;
        if (neg)
        begin
            f = (r0 != '0) ? (den - r0) : '0;
        end
        floor_f = f;
    endfunction

    function automatic logic signed [RW-1:0] rnd(input logic signed [RW-1:0] t,
                                                 input logic [C-1:0] f,
                                                 input logic [C-1:0] den);
        logic [C:0] f2;
        logic [C:0] d2;
        logic       up;
        f2  = {f, 1'b0};
        d2  = {1'b0, den};
        up  = (t >= 0) ? (f2 >= d2) : (f2 > d2);
        rnd = t + {{(RW-1){1'b0}}, up};
    endfunction

    function automatic logic [C-1:0] sat(input logic signed [RW-1:0] v);
        logic [C-1:0] r;
        if (v > MAXV)
        begin
            r = MAXV[C-1:0];
        end
        else if (v < MINV)
        begin
            r = MINV[C-1:0];
        end
        else
        begin
            r = v[C-1:0];
        end
        sat = r;
    endfunction

    logic            en;
    logic            w_hit;
    logic [4*C-1:0]  w_src;
    logic [C-1:0]    w_dl, w_dt;
    logic [C:0]      w_spanx, w_spany;
    logic [C-1:0]    w_numl, w_numr, w_numt, w_numb, w_denx, w_deny;
    logic [C:0]      magx, magy;
    logic [2*C+1:0]  pl_full, pr_full, pt_full, pb_full;

    logic [NB-1:0]   pl_reg, pr_reg, pt_reg, pb_reg;
    logic [SBW-1:0]  sb_reg [NB+1];
    logic            v_reg  [NB+1];

    logic [NB-1:0]   ql, qr, qt, qb;
    logic [C-1:0]    rl, rr, rt, rb;

    logic            e_hit;
    logic [4*C-1:0]  e_src;
    logic [C-1:0]    e_dl, e_dt;
    logic            e_negx, e_negy;
    logic [C-1:0]    e_denx, e_deny;
    logic signed [RW-1:0] nl, nr, nt, nb;

    logic            out_valid_reg;
    logic            hit_reg;
    logic [C-1:0]    osl_reg, ost_reg, osr_reg, osb_reg;
    logic [C-1:0]    odl_reg, odt_reg, odr_reg, odb_reg;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    assign {w_hit, w_src, w_dl, w_dt, w_spanx, w_spany,
            w_numl, w_numr, w_numt, w_numb, w_denx, w_deny} = in_word;

    assign magx = w_spanx[C] ? (~w_spanx + 1'b1) : w_spanx;
    assign magy = w_spany[C] ? (~w_spany + 1'b1) : w_spany;

    assign pl_full = magx * {1'b0, w_numl};
    assign pr_full = magx * {1'b0, w_numr};
    assign pt_full = magy * {1'b0, w_numt};
    assign pb_full = magy * {1'b0, w_numb};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pl_reg    <= pl_full[NB-1:0];
            pr_reg    <= pr_full[NB-1:0];
            pt_reg    <= pt_full[NB-1:0];
            pb_reg    <= pb_full[NB-1:0];
            sb_reg[0] <= {w_hit, w_src, w_dl, w_dt, w_spanx[C], w_spany[C], w_denx, w_deny};
            for (int s = 1; s <= NB; s++)
            begin
                sb_reg[s] <= sb_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= NB; s++)
            begin
                v_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int s = 1; s <= NB; s++)
            begin
                v_reg[s] <= v_reg[s-1];
            end
        end
    end

    brcs_div #(.NB(NB), .DB(C)) u_div_l (
        .clk(clk), .en(en), .dividend(pl_reg), .divisor(sb_reg[0][2*C-1:C]),
        .quotient(ql), .remainder(rl)
    );

    brcs_div #(.NB(NB), .DB(C)) u_div_r (
        .clk(clk), .en(en), .dividend(pr_reg), .divisor(sb_reg[0][2*C-1:C]),
        .quotient(qr), .remainder(rr)
    );

    brcs_div #(.NB(NB), .DB(C)) u_div_t (
        .clk(clk), .en(en), .dividend(pt_reg), .divisor(sb_reg[0][C-1:0]),
        .quotient(qt), .remainder(rt)
    );

    brcs_div #(.NB(NB), .DB(C)) u_div_b (
        .clk(clk), .en(en), .dividend(pb_reg), .divisor(sb_reg[0][C-1:0]),
        .quotient(qb), .remainder(rb)
    );

    assign {e_hit, e_src, e_dl, e_dt, e_negx, e_negy, e_denx, e_deny} = sb_reg[NB];

    // right and bottom edges start from the moved left and top edges
    assign nl = rnd({{(RW-C){e_dl[C-1]}}, e_dl} + floor_q(e_negx, ql, rl),
                    floor_f(e_negx, rl, e_denx), e_denx);
    assign nr = rnd(nl + floor_q(e_negx, qr, rr), floor_f(e_negx, rr, e_denx), e_denx);
    assign nt = rnd({{(RW-C){e_dt[C-1]}}, e_dt} + floor_q(e_negy, qt, rt),
                    floor_f(e_negy, rt, e_deny), e_deny);
    assign nb = rnd(nt + floor_q(e_negy, qb, rb), floor_f(e_negy, rb, e_deny), e_deny);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= v_reg[NB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg <= e_hit;
            if (e_hit)
            begin
                {osl_reg, ost_reg, osr_reg, osb_reg} <= e_src;
                odl_reg <= sat(nl);
                odt_reg <= sat(nt);
                odr_reg <= sat(nr);
                odb_reg <= sat(nb);
            end
            else
            begin
                {osl_reg, ost_reg, osr_reg, osb_reg} <= '0;
                odl_reg <= '0;
                odt_reg <= '0;
                odr_reg <= '0;
                odb_reg <= '0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign hit            = hit_reg;
    assign out_src_left   = osl_reg;
    assign out_src_top    = ost_reg;
    assign out_src_right  = osr_reg;
    assign out_src_bottom = osb_reg;
    assign out_dst_left   = odl_reg;
    assign out_dst_top    = odt_reg;
    assign out_dst_right  = odr_reg;
    assign out_dst_bottom = odb_reg;

endmodule
